// ===== rtl/rqe_pkg.sv =====
// Shared types, constants and tables for the relative quaternion to Euler block.
// Used by rqe_ctrl, rqe_dp and relative_quaternion_to_euler.
`default_nettype none

package rqe_pkg;

    localparam int QUAT_W   = 16;
    localparam int QREL_W   = 20;
    localparam int PROD_W   = 40;
    localparam int ACC_W    = 42;
    localparam int S30_W    = 32;
    localparam int RAD_W    = 61;
    localparam int ROOTR_W  = 63;
    localparam int ZACC_W   = 34;
    localparam int ANG_W    = 17;
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 15;
    localparam int YAW_W    = 16;
    localparam int STEP_W   = 5;

    localparam int QUAT_FRAC_BITS    = 14;
    localparam int ANGLE_FRAC_BITS   = 13;
    localparam int CORDIC_ITERATIONS = 16;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;
    localparam logic signed [QUAT_W-1:0] QUAT_MIN = -16'sd32768;
    localparam logic signed [QUAT_W-1:0] QUAT_MAX = 16'sd32767;

    localparam logic signed [ACC_W-1:0] QROUND = 42'sd8192;
    localparam logic signed [ACC_W-1:0] ONE28  = 42'sd268435456;
    localparam logic signed [ACC_W-1:0] ONE30  = 42'sd1073741824;
    localparam logic signed [ZACC_W-1:0] PI30  = 34'sd3373259427;
    localparam logic signed [ZACC_W-1:0] AROUND = 34'sd65536;
    localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;

    // Last step of each phase
    localparam logic [STEP_W-1:0] QUAT_LAST  = 5'd15;
    localparam logic [STEP_W-1:0] EUL_LAST   = 5'd9;
    localparam logic [STEP_W-1:0] ROOT_LAST  = 5'd31;
    localparam logic [STEP_W-1:0] ITER_LAST  = 5'(CORDIC_ITERATIONS - 1);

    // Euler term pairs
    localparam logic [2:0] EUL_RN = 3'd0;
    localparam logic [2:0] EUL_RD = 3'd1;
    localparam logic [2:0] EUL_YN = 3'd2;
    localparam logic [2:0] EUL_YD = 3'd3;
    localparam logic [2:0] EUL_S  = 3'd4;

    // CORDIC passes
    localparam logic [1:0] CORD_ROLL  = 2'd0;
    localparam logic [1:0] CORD_PITCH = 2'd1;
    localparam logic [1:0] CORD_YAW   = 2'd2;

    // Hamilton product conj(ref) * raw: a index is the term, b index and sign below
    localparam logic [1:0] HAM_B_IDX [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd3, 2'd0, 2'd1,
        2'd3, 2'd2, 2'd1, 2'd0
    };
    localparam logic [15:0] HAM_NEG = 16'h428E;

    // Euler products over the relative quaternion (w=0, x=1, y=2, z=3)
    localparam logic [1:0] EUL_A_IDX [10] = '{
        2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3
    };
    localparam logic [1:0] EUL_B_IDX [10] = '{
        2'd1, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2, 2'd1
    };
    localparam logic [9:0] EUL_NEG = 10'b10_0000_0000;

    localparam logic signed [ZACC_W-1:0] ATAN_TAB [CORDIC_ITERATIONS] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF
    };

    typedef struct packed {
        logic              capture;
        logic              load_raw;
        logic              mac_en;
        logic              mac_euler;
        logic              square;
        logic              root_en;
        logic              cord_load;
        logic              cord_shift;
        logic              cord_quad;
        logic              cord_iter;
        logic              cord_save;
        logic [1:0]        cord_sel;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic in_range;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/relative_quaternion_to_euler.sv =====
// A sample word passes the quaternion and Euler MAC phases, the root and the CORDIC prescale
// shifts and passes from acceptance to result; a capture word gives no result.
// Throughput: one sample at a time, set by the shared MAC, the 32-step root and
// three 16-step passes of one CORDIC unit. A waiting result does not block a capture.
// Reset (synchronous, active low): raw sample and reference set to identity, invert off.
// Depends on rqe_pkg, rqe_ctrl and rqe_dp.
`default_nettype none

module relative_quaternion_to_euler (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_command,
    input  wire signed [rqe_pkg::QUAT_W-1:0]   i_quat_w,
    input  wire signed [rqe_pkg::QUAT_W-1:0]   i_quat_x,
    input  wire signed [rqe_pkg::QUAT_W-1:0]   i_quat_y,
    input  wire signed [rqe_pkg::QUAT_W-1:0]   i_quat_z,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [rqe_pkg::ROLL_W-1:0]  o_roll_angle,
    output logic signed [rqe_pkg::PITCH_W-1:0] o_pitch_angle,
    output logic signed [rqe_pkg::YAW_W-1:0]   o_yaw_angle,
    input  wire                                i_cfg_wr_en,
    input  wire                                i_cfg_wr_data
);

    rqe_pkg::t_cmd    w_cmd;
    rqe_pkg::t_status w_status;

    rqe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_command(i_command),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    rqe_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_quat_w     (i_quat_w),
        .i_quat_x     (i_quat_x),
        .i_quat_y     (i_quat_y),
        .i_quat_z     (i_quat_z),
        .o_roll_angle (o_roll_angle),
        .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle  (o_yaw_angle)
    );

`ifndef SYNTHESIS
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_command) |=> o_stall)
        else $error("sample word did not start work");

    a_capture_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_command) |=> !o_stall)
        else $error("capture word blocked the input");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work in progress");
`endif

endmodule

`default_nettype wire

// ===== rtl/rqe_ctrl.sv =====
// Sequencer for the relative quaternion to Euler block.
// Depends on rqe_pkg; drives rqe_dp through t_cmd and reads t_status.
`default_nettype none

module rqe_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire              i_command,
    output logic             o_stall,
    output logic             o_valid,
    input  wire              i_stall,
    output rqe_pkg::t_cmd    o_cmd,
    input  rqe_pkg::t_status i_status
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_QUAT   = 11'b000_0000_0010,
        S_EULER  = 11'b000_0000_0100,
        S_SQUARE = 11'b000_0000_1000,
        S_ROOT   = 11'b000_0001_0000,
        S_CLOAD  = 11'b000_0010_0000,
        S_CSHIFT = 11'b000_0100_0000,
        S_CQUAD  = 11'b000_1000_0000,
        S_CITER  = 11'b001_0000_0000,
        S_CSAVE  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [rqe_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic [1:0]                 r_sel, n_sel;
    logic                       r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.step     = r_cnt;
        o_cmd.cord_sel = r_sel;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_command) begin
                        o_cmd.capture = 1'b1;
                    end else begin
                        o_cmd.load_raw = 1'b1;
                        n_cnt   = '0;
                        n_state = S_QUAT;
                    end
                end
            end
            S_QUAT: begin
                o_cmd.mac_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rqe_pkg::QUAT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_EULER;
                end
            end
            S_EULER: begin
                o_cmd.mac_en    = 1'b1;
                o_cmd.mac_euler = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rqe_pkg::EUL_LAST) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_cnt   = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rqe_pkg::ROOT_LAST) begin
                    n_cnt   = '0;
                    n_sel   = rqe_pkg::CORD_ROLL;
                    n_state = S_CLOAD;
                end
            end
            S_CLOAD: begin
                o_cmd.cord_load = 1'b1;
                n_state = S_CSHIFT;
            end
            S_CSHIFT: begin
                if (i_status.in_range) begin
                    n_state = S_CQUAD;
                end else begin
                    o_cmd.cord_shift = 1'b1;
                end
            end
            S_CQUAD: begin
                o_cmd.cord_quad = 1'b1;
                n_cnt   = '0;
                n_state = S_CITER;
            end
            S_CITER: begin
                o_cmd.cord_iter = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rqe_pkg::ITER_LAST) begin
                    n_state = S_CSAVE;
                end
            end
            S_CSAVE: begin
                o_cmd.cord_save = 1'b1;
                if (r_sel == rqe_pkg::CORD_YAW) begin
                    n_state = S_OUT;
                end else begin
                    n_sel   = r_sel + 1'b1;
                    n_state = S_CLOAD;
                end
            end
            S_OUT: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== rtl/rqe_dp.sv =====
// Datapath: sample and reference store, shared MAC, square root and CORDIC unit.
// Depends on rqe_pkg; sequenced by rqe_ctrl through t_cmd.
`default_nettype none

module rqe_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  rqe_pkg::t_cmd                         i_cmd,
    output rqe_pkg::t_status                      o_status,
    input  wire                                   i_cfg_wr_en,
    input  wire                                   i_cfg_wr_data,
    input  wire signed [rqe_pkg::QUAT_W-1:0]      i_quat_w,
    input  wire signed [rqe_pkg::QUAT_W-1:0]      i_quat_x,
    input  wire signed [rqe_pkg::QUAT_W-1:0]      i_quat_y,
    input  wire signed [rqe_pkg::QUAT_W-1:0]      i_quat_z,
    output logic signed [rqe_pkg::ROLL_W-1:0]     o_roll_angle,
    output logic signed [rqe_pkg::PITCH_W-1:0]    o_pitch_angle,
    output logic signed [rqe_pkg::YAW_W-1:0]      o_yaw_angle
);

    logic                                r_invert;
    logic signed [rqe_pkg::QUAT_W-1:0]   r_raw  [4];
    logic signed [rqe_pkg::QUAT_W-1:0]   r_conj [4];
    logic signed [rqe_pkg::QREL_W-1:0]   r_q    [4];
    logic signed [rqe_pkg::ACC_W-1:0]    r_acc;
    logic signed [rqe_pkg::ACC_W-1:0]    r_rn, r_rd, r_yn, r_yd;
    logic signed [rqe_pkg::S30_W-1:0]    r_s30;
    logic [rqe_pkg::RAD_W-1:0]           r_rad;
    logic [rqe_pkg::ROOTR_W-1:0]         r_root;
    logic signed [rqe_pkg::ACC_W-1:0]    r_cx, r_cy;
    logic signed [rqe_pkg::ZACC_W-1:0]   r_cz;
    logic                                r_zero;
    logic signed [rqe_pkg::ANG_W-1:0]    r_ang_roll, r_ang_pitch, r_ang_yaw;
    logic signed [rqe_pkg::ROLL_W-1:0]   r_roll;
    logic signed [rqe_pkg::PITCH_W-1:0]  r_pitch;
    logic signed [rqe_pkg::YAW_W-1:0]    r_yaw;

    // MAC
    logic [3:0]                          w_st;
    logic signed [rqe_pkg::QREL_W-1:0]   w_opa, w_opb;
    logic signed [rqe_pkg::PROD_W-1:0]   w_prod;
    logic                                w_neg, w_first, w_last;
    logic signed [rqe_pkg::ACC_W-1:0]    w_term, w_sum, w_qr, w_dbl, w_sc;

    assign w_st = i_cmd.step[3:0];

    always_comb begin
        if (i_cmd.mac_euler) begin
            w_opa   = r_q[rqe_pkg::EUL_A_IDX[w_st]];
            w_opb   = r_q[rqe_pkg::EUL_B_IDX[w_st]];
            w_neg   = rqe_pkg::EUL_NEG[w_st];
            w_first = !w_st[0];
            w_last  = w_st[0];
        end else begin
            w_opa   = rqe_pkg::QREL_W'(r_conj[w_st[1:0]]);
            w_opb   = rqe_pkg::QREL_W'(r_raw[rqe_pkg::HAM_B_IDX[w_st]]);
            w_neg   = rqe_pkg::HAM_NEG[w_st];
            w_first = (w_st[1:0] == 2'd0);
            w_last  = (w_st[1:0] == 2'd3);
        end
        w_prod = w_opa * w_opb;
        w_term = w_neg ? -rqe_pkg::ACC_W'(w_prod) : rqe_pkg::ACC_W'(w_prod);
        w_sum  = (w_first ? '0 : r_acc) + w_term;
        w_qr   = (w_sum + rqe_pkg::QROUND) >>> rqe_pkg::QUAT_FRAC_BITS;
        w_dbl  = w_sum <<< 1;
        if (w_dbl > rqe_pkg::ONE28) begin
            w_sc = rqe_pkg::ONE28;
        end else if (w_dbl < -rqe_pkg::ONE28) begin
            w_sc = -rqe_pkg::ONE28;
        end else begin
            w_sc = w_dbl;
        end
    end

    // Square and root
    logic signed [63:0]            w_sq;
    logic [5:0]                    w_bsh;
    logic [rqe_pkg::ROOTR_W-1:0]   w_bit;
    logic [63:0]                   w_trial;
    logic                          w_take;

    always_comb begin
        w_sq    = r_s30 * r_s30;
        w_bsh   = {~i_cmd.step, 1'b0};
        w_bit   = rqe_pkg::ROOTR_W'(1) << w_bsh;
        w_trial = {1'b0, r_root} + {1'b0, w_bit};
        w_take  = ({3'b000, r_rad} >= w_trial);
    end

    // CORDIC
    logic signed [rqe_pkg::ACC_W-1:0]   w_ly, w_lx, w_dx, w_dy;
    logic signed [rqe_pkg::ZACC_W-1:0]  w_t, w_zr;
    logic signed [rqe_pkg::ANG_W-1:0]   w_ang;

    always_comb begin
        case (i_cmd.cord_sel)
            rqe_pkg::CORD_ROLL: begin
                w_ly = r_rn;
                w_lx = r_rd;
            end
            rqe_pkg::CORD_PITCH: begin
                w_ly = rqe_pkg::ACC_W'(r_s30);
                w_lx = rqe_pkg::ACC_W'($signed({1'b0, r_root[30:0]}));
            end
            rqe_pkg::CORD_YAW: begin
                w_ly = r_yn;
                w_lx = r_yd;
            end
            default: begin
                w_ly = '0;
                w_lx = '0;
            end
        endcase
        w_dx  = r_cy >>> w_st;
        w_dy  = r_cx >>> w_st;
        w_t   = rqe_pkg::ATAN_TAB[w_st];
        w_zr  = (r_cz + rqe_pkg::AROUND) >>> (30 - rqe_pkg::ANGLE_FRAC_BITS);
        w_ang = w_zr[rqe_pkg::ANG_W-1:0];
        o_status.in_range = (r_cy < rqe_pkg::ONE30) && (r_cy > -rqe_pkg::ONE30) &&
                            (r_cx < rqe_pkg::ONE30) && (r_cx > -rqe_pkg::ONE30);
    end

    // Control state: config, raw sample and reference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_raw[0] <= rqe_pkg::QUAT_ONE;
            r_raw[1] <= '0;
            r_raw[2] <= '0;
            r_raw[3] <= '0;
            r_conj[0] <= rqe_pkg::QUAT_ONE;
            r_conj[1] <= '0;
            r_conj[2] <= '0;
            r_conj[3] <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_invert <= i_cfg_wr_data;
            end
            if (i_cmd.load_raw) begin
                r_raw[0] <= i_quat_w;
                r_raw[1] <= i_quat_x;
                r_raw[2] <= i_quat_y;
                r_raw[3] <= i_quat_z;
            end
            if (i_cmd.capture) begin
                r_conj[0] <= r_raw[0];
                for (int k = 1; k < 4; k++) begin
                    r_conj[k] <= (r_raw[k] == rqe_pkg::QUAT_MIN) ? rqe_pkg::QUAT_MAX
                                                                 : -r_raw[k];
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_acc <= w_sum;
            if (w_last && !i_cmd.mac_euler) begin
                r_q[w_st[3:2]] <= w_qr[rqe_pkg::QREL_W-1:0];
            end
            if (w_last && i_cmd.mac_euler) begin
                case (w_st[3:1])
                    rqe_pkg::EUL_RN: r_rn  <= w_dbl;
                    rqe_pkg::EUL_RD: r_rd  <= rqe_pkg::ONE28 - w_dbl;
                    rqe_pkg::EUL_YN: r_yn  <= w_dbl;
                    rqe_pkg::EUL_YD: r_yd  <= rqe_pkg::ONE28 - w_dbl;
                    rqe_pkg::EUL_S:  r_s30 <= {w_sc[rqe_pkg::S30_W-3:0], 2'b00};
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.square) begin
            r_rad  <= rqe_pkg::RAD_W'(rqe_pkg::ONE60 - 64'(w_sq));
            r_root <= '0;
        end
        if (i_cmd.root_en) begin
            if (w_take) begin
                r_rad  <= r_rad - w_trial[rqe_pkg::RAD_W-1:0];
                r_root <= (r_root >> 1) + w_bit;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        if (i_cmd.cord_load) begin
            r_cy   <= w_ly;
            r_cx   <= w_lx;
            r_zero <= (w_ly == '0) && (w_lx == '0);
        end
        if (i_cmd.cord_shift) begin
            r_cy <= r_cy >>> 1;
            r_cx <= r_cx >>> 1;
        end
        if (i_cmd.cord_quad) begin
            if (r_cx < 0) begin
                r_cz <= (r_cy >= 0) ? rqe_pkg::PI30 : -rqe_pkg::PI30;
                r_cx <= -r_cx;
                r_cy <= -r_cy;
            end else begin
                r_cz <= '0;
            end
        end
        if (i_cmd.cord_iter && !r_zero) begin
            if (r_cy > 0) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_t;
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_t;
            end
        end
        if (i_cmd.cord_save) begin
            case (i_cmd.cord_sel)
                rqe_pkg::CORD_ROLL:  r_ang_roll  <= w_ang;
                rqe_pkg::CORD_PITCH: r_ang_pitch <= w_ang;
                default:             r_ang_yaw   <= w_ang;
            endcase
        end
        if (i_cmd.out_load) begin
            r_roll  <= r_invert ? -r_ang_roll[rqe_pkg::ROLL_W-1:0]
                                : r_ang_roll[rqe_pkg::ROLL_W-1:0];
            r_pitch <= r_invert ? -r_ang_pitch[rqe_pkg::PITCH_W-1:0]
                                : r_ang_pitch[rqe_pkg::PITCH_W-1:0];
            r_yaw   <= r_invert ? -r_ang_yaw[rqe_pkg::YAW_W-1:0]
                                : r_ang_yaw[rqe_pkg::YAW_W-1:0];
        end
    end

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
    assign o_yaw_angle   = r_yaw;

endmodule

`default_nettype wire

// ===== tb/tb_relative_quaternion_to_euler.sv =====
// Self-checking bench for relative_quaternion_to_euler: random and directed samples and
// captures, a bit-exact Euler angle predictor, and random stalls on both sides.
// Depends on rqe_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_relative_quaternion_to_euler;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct packed {
        logic signed [rqe_pkg::ROLL_W-1:0]  roll;
        logic signed [rqe_pkg::PITCH_W-1:0] pitch;
        logic signed [rqe_pkg::YAW_W-1:0]   yaw;
    } t_angles;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_command;
    logic signed [rqe_pkg::QUAT_W-1:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic                              o_valid;
    logic                              i_stall;
    logic signed [rqe_pkg::ROLL_W-1:0]  o_roll_angle;
    logic signed [rqe_pkg::PITCH_W-1:0] o_pitch_angle;
    logic signed [rqe_pkg::YAW_W-1:0]   o_yaw_angle;
    logic                              i_cfg_wr_en;
    logic                              i_cfg_wr_data;

    t_angles angle_q[$];
    longint  raw_q[4];
    longint  ref_conj[4];
    bit      invert_on;
    int      mismatches;
    int      idle_cycles;
    bit      rx_quiet;
    bit      tx_quiet;
    bit      hold_req;

    relative_quaternion_to_euler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_command(i_command),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y), .i_quat_z(i_quat_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle(o_yaw_angle),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint round_quat(longint v);
        return (v + (64'sd1 <<< (rqe_pkg::QUAT_FRAC_BITS - 1))) >>> rqe_pkg::QUAT_FRAC_BITS;
    endfunction

    function automatic longint round_angle(longint z30);
        return (z30 + (64'sd1 <<< (29 - rqe_pkg::ANGLE_FRAC_BITS)))
               >>> (30 - rqe_pkg::ANGLE_FRAC_BITS);
    endfunction

    function automatic longint sat_negate(longint v);
        longint r;
        r = -v;
        return (r > 32767) ? 64'sd32767 : r;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy, lim;
        z = 0;
        lim = 64'sd1 <<< 30;
        if (x == 0 && y == 0) return 0;
        while (y >= lim || y <= -lim || x >= lim || x <= -lim) begin
            y = y >>> 1;
            x = x >>> 1;
        end
        if (x < 0) begin
            z = (y >= 0) ? longint'(rqe_pkg::PI30) : -longint'(rqe_pkg::PI30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < rqe_pkg::CORDIC_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + longint'(rqe_pkg::ATAN_TAB[i]);
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(rqe_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    task automatic predict_euler(input bit cmd, input logic signed [rqe_pkg::QUAT_W-1:0] qw,
                                 input logic signed [rqe_pkg::QUAT_W-1:0] qx,
                                 input logic signed [rqe_pkg::QUAT_W-1:0] qy,
                                 input logic signed [rqe_pkg::QUAT_W-1:0] qz);
        longint aw, ax, ay, az, bw, bx, by, bz, w, x, y, z;
        longint one2, rn, rd, yn, yd, s, s30, roll, pitch, yaw;
        longint unsigned c;
        t_angles a;
        if (cmd) begin
            ref_conj[0] = raw_q[0];
            ref_conj[1] = sat_negate(raw_q[1]);
            ref_conj[2] = sat_negate(raw_q[2]);
            ref_conj[3] = sat_negate(raw_q[3]);
            return;
        end
        bw = qw; bx = qx; by = qy; bz = qz;
        raw_q[0] = bw; raw_q[1] = bx; raw_q[2] = by; raw_q[3] = bz;
        aw = ref_conj[0]; ax = ref_conj[1]; ay = ref_conj[2]; az = ref_conj[3];
        w = round_quat(aw * bw - ax * bx - ay * by - az * bz);
        x = round_quat(aw * bx + ax * bw + ay * bz - az * by);
        y = round_quat(aw * by - ax * bz + ay * bw + az * bx);
        z = round_quat(aw * bz + ax * by - ay * bx + az * bw);
        one2 = 64'sd1 <<< (2 * rqe_pkg::QUAT_FRAC_BITS);
        rn = 2 * (w * x + y * z);
        rd = one2 - 2 * (x * x + y * y);
        yn = 2 * (w * z + x * y);
        yd = one2 - 2 * (y * y + z * z);
        s = 2 * (w * y - z * x);
        if (s > one2) s = one2;
        if (s < -one2) s = -one2;
        s30 = s * (64'sd1 <<< (30 - 2 * rqe_pkg::QUAT_FRAC_BITS));
        c = root_floor((64'd1 << 60) - longint'(s30 * s30));
        roll  = round_angle(vector_angle(rn, rd));
        pitch = round_angle(vector_angle(s30, longint'(c)));
        yaw   = round_angle(vector_angle(yn, yd));
        if (invert_on) begin
            roll = -roll; pitch = -pitch; yaw = -yaw;
        end
        a.roll  = roll[rqe_pkg::ROLL_W-1:0];
        a.pitch = pitch[rqe_pkg::PITCH_W-1:0];
        a.yaw   = yaw[rqe_pkg::YAW_W-1:0];
        angle_q.push_back(a);
    endtask

    task automatic send_word(input bit cmd, input logic signed [rqe_pkg::QUAT_W-1:0] qw,
                             input logic signed [rqe_pkg::QUAT_W-1:0] qx,
                             input logic signed [rqe_pkg::QUAT_W-1:0] qy,
                             input logic signed [rqe_pkg::QUAT_W-1:0] qz);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_quat_w  <= qw;
        i_quat_x  <= qx;
        i_quat_y  <= qy;
        i_quat_z  <= qz;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
        end
        @(posedge i_clk);
        predict_euler(cmd, qw, qx, qy, qz);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_invert(input bit v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        invert_on = v;
    endtask

    function automatic logic signed [rqe_pkg::QUAT_W-1:0] rand_comp(int mode);
        if (mode == 0) return rqe_pkg::QUAT_W'($urandom_range(0, 32768) - 16384);
        return rqe_pkg::QUAT_W'($urandom());
    endfunction

    // receive side: random stalls, optional long hold, compare each word
    initial begin
        int n;
        t_angles exp_a;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = rx_quiet ? 0 : $urandom_range(0, 18);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            forever begin
                @(negedge i_clk);
                if (o_valid) break;
            end
            @(posedge i_clk);
            if (angle_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: roll %0d pitch %0d yaw %0d",
                             o_roll_angle, o_pitch_angle, o_yaw_angle);
            end else begin
                exp_a = angle_q.pop_front();
                if (exp_a.roll !== o_roll_angle || exp_a.pitch !== o_pitch_angle ||
                    exp_a.yaw !== o_yaw_angle) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 exp_a.roll, exp_a.pitch, exp_a.yaw,
                                 o_roll_angle, o_pitch_angle, o_yaw_angle);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        send_word(1'b0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_word(1'b0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        send_word(1'b0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0);
        send_word(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
        send_word(1'b0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
        send_word(1'b0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_word(1'b0, rqe_pkg::QUAT_MAX, rqe_pkg::QUAT_MIN, rqe_pkg::QUAT_MAX,
                  rqe_pkg::QUAT_MIN);
        send_word(1'b0, rqe_pkg::QUAT_MIN, rqe_pkg::QUAT_MIN, rqe_pkg::QUAT_MIN,
                  rqe_pkg::QUAT_MIN);
        send_word(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd16384, 16'sd16384, -16'sd16384, 16'sd100);
        send_word(1'b0, 16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
        send_word(1'b1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_word(1'b0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
        send_word(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(1'b0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        write_invert(1'b1);
        send_word(1'b0, 16'sd11585, 16'sd5000, -16'sd7000, 16'sd3000);
        send_word(1'b0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
        write_invert(1'b0);
    endtask

    task automatic test_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (i == count / 3) write_invert(1'b1);
            if (i == 2 * count / 3) write_invert(1'b0);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_word(1'b1, rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
            else if (r < 85)
                send_word(1'b0, rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
            else
                send_word(1'b0, rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
        end
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        for (int i = 0; i < 12; i++)
            send_word(i % 5 == 4, rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
        tx_quiet = 1'b0;
        wait_drained();
        for (int i = 0; i < 6; i++)
            send_word(1'b0, rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= 1'b0;
        i_quat_w      <= '0;
        i_quat_x      <= '0;
        i_quat_y      <= '0;
        i_quat_z      <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        hold_req = 1'b0;
        invert_on = 1'b0;
        raw_q = '{64'sd16384, 0, 0, 0};
        ref_conj = '{64'sd16384, 0, 0, 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_invert(1'b0);
        test_directed();
        test_backpressure();
        test_random(1700);
        wait_drained();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
